/* src/pts_pkg.sv */
// Package for point-to-point steering: constants, types, arctangent table.
// No dependencies.
package pts_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_WIDTH_DEF  = 16;
  localparam int TABLE_LEN        = 24;
  localparam int ANG_W            = 20;
  localparam int REG_W            = 16;
  localparam int IDX_W            = 3;

  localparam logic signed [ANG_W-1:0] PI_Q16      = 20'sd205887;
  localparam logic signed [15:0]      PI_Q12      = 16'sd12868;
  localparam logic signed [15:0]      HALF_PI_Q12 = 16'sd6434;
  localparam logic signed [15:0]      TURN_MIN    = -16'sd23040;
  localparam logic signed [15:0]      TURN_MAX    = 16'sd5760;

  // degrees = round(mag * 11520 / 12868) = floor((mag * 2880 + 1608) / 3217),
  // the division done by a reciprocal multiply, exact below 2^27
  localparam logic [11:0] DEG_MUL   = 12'd2880;
  localparam logic [10:0] DEG_RND   = 11'd1608;
  localparam logic [27:0] DEG_RECIP = 28'd170890835;
  localparam int          DEG_SHIFT = 39;

  localparam logic [IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_DEADBAND = 3'd1;
  localparam logic [IDX_W-1:0] REG_ARRIVE   = 3'd2;
  localparam logic [IDX_W-1:0] REG_TLIMIT   = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAXSPD   = 3'd4;

  typedef struct packed {
    logic        mode;
    logic [11:0] turn_deadband;
    logic [15:0] arrive_distance;
    logic [13:0] turn_limit;
    logic [15:0] max_speed;
  } cfg_t;

  function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] i);
    logic [ANG_W-1:0] r;
    begin
      case (i)
        5'd0:  r = 20'd51472;
        5'd1:  r = 20'd30385;
        5'd2:  r = 20'd16055;
        5'd3:  r = 20'd8150;
        5'd4:  r = 20'd4091;
        5'd5:  r = 20'd2047;
        5'd6:  r = 20'd1024;
        5'd7:  r = 20'd512;
        5'd8:  r = 20'd256;
        5'd9:  r = 20'd128;
        5'd10: r = 20'd64;
        5'd11: r = 20'd32;
        5'd12: r = 20'd16;
        5'd13: r = 20'd8;
        5'd14: r = 20'd4;
        5'd15: r = 20'd2;
        5'd16: r = 20'd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

/* src/pts_if.sv */
// Valid/ready channel interfaces for the steering block.
// Depends on nothing.
interface pts_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] heading_x;
  logic signed [W-1:0] heading_y;
  logic signed [W-1:0] location_x;
  logic signed [W-1:0] location_y;
  logic signed [W-1:0] dest_x;
  logic signed [W-1:0] dest_y;
  modport source (output valid, heading_x, heading_y, location_x, location_y, dest_x,
                  dest_y, input ready);
  modport sink (input valid, heading_x, heading_y, location_x, location_y, dest_x,
                dest_y, output ready);
endinterface

interface pts_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] turn_deg;
  logic        [15:0] translate;
  modport source (output valid, turn_deg, translate, input ready);
  modport sink (input valid, turn_deg, translate, output ready);
endinterface

/* src/point_to_point_steering_top.sv */
// Point-to-point steering controller: top level, sequencer and output stage.
// Depends on pts_pkg, pts_if, pts_cordic, pts_isqrt.
// Input is accepted only while idle, after the previous result beat has been taken; outside
//   test mode the shared CORDIC runs twice per item, the square root runs alongside the
//   second bearing.
// Reset (rst, synchronous): registers take their defaults, sequencer idle.
module point_to_point_steering_top #(
  parameter int CORDIC_STEPS = pts_pkg::CORDIC_STEPS_DEF,
  parameter int COORD_WIDTH  = pts_pkg::COORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pts_pkg::IDX_W-1:0]   cfg_index,
  input  logic [pts_pkg::REG_W-1:0]   cfg_data,
  pts_in_if.sink                      in_ch,
  pts_out_if.source                   out_ch
);
  import pts_pkg::*;

  localparam int XW = COORD_WIDTH + 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CUR  = 7'b0000010,
    S_DES  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;
  cfg_t   cfg;

  logic signed [XW-1:0] hdx, hdy, ddx, ddy;
  logic signed [XW-1:0] cvx, cvy;
  logic                 c_start, c_done;
  logic signed [15:0]   c_angle;
  logic signed [15:0]   cur;
  logic                 s_start, s_done;
  logic [35:0]          sq;
  logic [17:0]          root;
  logic [17:0]          distance;
  logic                 huge;
  logic [XW-1:0]        ax, ay;
  logic signed [16:0]   change;
  logic signed [15:0]   turn;
  logic [14:0]          tmag;
  logic [26:0]          prod;
  logic [54:0]          qprod;
  logic                 sdone_seen;
  logic [15:0]          dmag;
  logic signed [15:0]   deg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= 1'b0;
      cfg.turn_deadband   <= 12'd4;
      cfg.arrive_distance <= 16'd26;
      cfg.turn_limit      <= 14'd1229;
      cfg.max_speed       <= 16'd384;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:     cfg.mode            <= cfg_data[0];
        REG_DEADBAND: cfg.turn_deadband   <= cfg_data[11:0];
        REG_ARRIVE:   cfg.arrive_distance <= cfg_data;
        REG_TLIMIT:   cfg.turn_limit      <= cfg_data[13:0];
        REG_MAXSPD:   cfg.max_speed       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ax = ddx < 0 ? XW'(-ddx) : XW'(ddx);
  assign ay = ddy < 0 ? XW'(-ddy) : XW'(ddy);
  // squares fit 36 bits only below 2^17
  always_comb begin
    logic [XW-1:0] lim;
    lim  = XW'(0);
    huge = 1'b0;
    if (XW > 17) begin
      lim  = XW'(1) << (XW > 17 ? 17 : 0);
      huge = (ax >= lim) || (ay >= lim);
    end
    sq = 36'(ax[(XW > 17 ? 17 : XW)-1:0]) * 36'(ax[(XW > 17 ? 17 : XW)-1:0])
       + 36'(ay[(XW > 17 ? 17 : XW)-1:0]) * 36'(ay[(XW > 17 ? 17 : XW)-1:0]);
  end

  assign cvx = (state == S_IDLE || state == S_CUR) ? hdy : ddy;
  assign cvy = (state == S_IDLE || state == S_CUR) ? hdx : ddx;

  pts_cordic #(.STEPS(CORDIC_STEPS), .XW(XW)) u_cordic (
    .clk(clk), .rst(rst), .start(c_start), .vx(cvx), .vy(cvy),
    .done(c_done), .angle(c_angle));

  pts_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(s_start), .v(sq), .done(s_done), .root(root));

  assign in_ch.ready = (state == S_IDLE);

  always_comb begin
    dmag = 16'(qprod >> DEG_SHIFT);
    deg  = turn < 0 ? -16'(dmag) : 16'(dmag);
    if (deg < TURN_MIN) deg = TURN_MIN;
    if (deg > TURN_MAX) deg = TURN_MAX;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      c_start      <= 1'b0;
      s_start      <= 1'b0;
      out_ch.valid <= 1'b0;
      sdone_seen   <= 1'b0;
    end else begin
      c_start <= 1'b0;
      s_start <= 1'b0;
      if (s_done) begin
        sdone_seen <= 1'b1;
        distance   <= huge ? 18'h2_0000 : root;
      end
      case (state)
        S_IDLE: if (in_ch.valid) begin
          hdx <= XW'(in_ch.heading_x) - XW'(in_ch.location_x);
          hdy <= XW'(in_ch.heading_y) - XW'(in_ch.location_y);
          ddx <= XW'(in_ch.dest_x) - XW'(in_ch.location_x);
          ddy <= XW'(in_ch.dest_y) - XW'(in_ch.location_y);
          sdone_seen <= 1'b0;
          if (cfg.mode) begin
            out_ch.turn_deg  <= '0;
            out_ch.translate <= '0;
            out_ch.valid     <= 1'b1;
            state            <= S_OUT;
          end else begin
            c_start <= 1'b1;
            state   <= S_CUR;
          end
        end
        S_CUR: if (c_done) begin
          cur     <= c_angle;
          c_start <= 1'b1;
          s_start <= 1'b1;
          state   <= S_DES;
        end
        S_DES: if (c_done) begin
          begin
            logic signed [16:0] ch;
            logic [16:0] m;
            ch = 17'(cur) - 17'(c_angle);
            if (ch > 17'(HALF_PI_Q12)) ch = ch - 17'(PI_Q12);
            if (ch > 17'(HALF_PI_Q12)) ch = ch - 17'(PI_Q12);
            m = ch < 0 ? 17'(-ch) : 17'(ch);
            change <= ch;
            if (m > 17'(cfg.turn_deadband)) begin
              turn <= 16'(ch);
              tmag <= 15'(m);
            end else begin
              turn <= '0;
              tmag <= '0;
            end
          end
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= 27'(tmag) * 27'(DEG_MUL) + 27'(DEG_RND);
          state <= S_DIV;
        end
        // divide by 3217 through the reciprocal
        S_DIV: begin
          qprod <= 55'(prod) * 55'(DEG_RECIP);
          state <= S_FIN;
        end
        S_FIN: if (sdone_seen) begin
          out_ch.turn_deg <= deg;
          if (distance > 18'(cfg.arrive_distance) && tmag < 15'(cfg.turn_limit))
            out_ch.translate <= distance < 18'(cfg.max_speed) ? 16'(distance)
                                                              : cfg.max_speed;
          else
            out_ch.translate <= '0;
          out_ch.valid <= 1'b1;
          state        <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          out_ch.valid <= 1'b0;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_valid_in_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> state == S_OUT) else $error("result outside output state");
  a_change_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> change <= 17'(HALF_PI_Q12)) else $error("change not wrapped");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
endmodule

/* src/pts_cordic.sv */
// Iterative CORDIC vectoring unit: one rotation step per cycle, Q3.12 angle out.
// Depends on pts_pkg.
module pts_cordic #(
  parameter int STEPS = pts_pkg::CORDIC_STEPS_DEF,
  parameter int XW    = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [XW-1:0]  vx,
  input  logic signed [XW-1:0]  vy,
  output logic                  done,
  output logic signed [15:0]    angle
);
  import pts_pkg::*;

  localparam int IW  = XW + 3;
  localparam int CW  = $clog2(STEPS + 1);

  logic signed [IW-1:0]    x, y;
  logic signed [ANG_W+1:0] z;
  logic [CW-1:0]           cnt;
  logic                    busy;
  logic                    zero;
  logic signed [IW-1:0]    xs, ys;
  logic [4:0]              sh;
  logic signed [ANG_W+1:0] zr;

  assign sh = 5'(cnt);
  assign xs = x >>> sh;
  assign ys = y >>> sh;

  // one micro-rotation per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        zero <= (vx == '0) && (vy == '0);
        if (vx < 0) begin
          x <= -IW'(vx);
          y <= -IW'(vy);
          z <= (vy >= 0) ? (ANG_W+2)'(PI_Q16) : -(ANG_W+2)'(PI_Q16);
        end else begin
          x <= IW'(vx);
          y <= IW'(vy);
          z <= '0;
        end
      end else if (busy) begin
        if (cnt == CW'(STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (y >= 0) begin
            x <= x + ys; y <= y - xs; z <= z + (ANG_W+2)'(atan_entry(sh));
          end else begin
            x <= x - ys; y <= y + xs; z <= z - (ANG_W+2)'(atan_entry(sh));
          end
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // round to Q3.12 and clamp
  always_comb begin
    zr = (z + $signed((ANG_W+2)'(8))) >>> 4;
    if (zero)                           angle = '0;
    else if (zr > (ANG_W+2)'(PI_Q12))   angle = PI_Q12;
    else if (zr < -(ANG_W+2)'(PI_Q12))  angle = -PI_Q12;
    else                                angle = 16'(zr);
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("cordic done without busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy || $past(start)) else $error("cordic busy after done");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt <= CW'(STEPS)) else $error("cordic count overrun");
endmodule

/* src/pts_isqrt.sv */
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on pts_pkg.
module pts_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [35:0] v,
  output logic        done,
  output logic [17:0] root
);
  import pts_pkg::*;

  logic [35:0] rem;
  logic [35:0] r;
  logic [35:0] bitv;
  logic        busy;
  logic [35:0] trial;

  assign trial = r + bitv;
  assign root  = 18'(r);

  // restoring square root, one result bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= v;
        r    <= '0;
        bitv <= 36'h4_0000_0000;
      end else if (busy) begin
        if (bitv == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (rem >= trial) begin
            rem <= rem - trial;
            r   <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          bitv <= bitv >> 2;
        end
      end
    end
  end

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("isqrt done without busy");
  a_bit_onehot: assert property (@(posedge clk) disable iff (rst)
    busy |-> $onehot0(bitv)) else $error("isqrt bit not one-hot");
  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> r < 36'h4_0000) else $error("isqrt root too wide");
endmodule

/* test/testbench.sv */
// Testbench for point_to_point_steering_top: directed and random steering beats,
// each result checked against an in-bench fixed-point predictor.
// Depends on pts_pkg, pts_if and the steering RTL.
`timescale 1ns / 1ps

module testbench;
  import pts_pkg::*;

  typedef struct {
    logic signed [15:0] turn_deg;
    logic        [15:0] translate;
  } steer_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [IDX_W-1:0]     cfg_index;
  logic [REG_W-1:0]     cfg_data;

  pts_in_if #(16) in_ch ();
  pts_out_if      out_ch ();

  point_to_point_steering_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // Shadow register set
  logic        sh_mode;
  logic [11:0] sh_deadband;
  logic [15:0] sh_arrive;
  logic [13:0] sh_tlimit;
  logic [15:0] sh_maxspd;

  steer_t steer_q[$];
  int     n_err;
  int     n_beats;
  int     n_results;
  int     n_turns;
  int     n_moves;

  longint atan_q16[24] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  // Vectoring CORDIC bearing from the y axis, Q3.12
  function automatic longint bearing_q12(longint a, longint b);
    longint x, y, z, xs, ys, q;
    x = b;
    y = a;
    z = 0;
    if (a == 0 && b == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 205887 : -205887;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_q16[i];
      end else begin
        x -= ys; y += xs; z -= atan_q16[i];
      end
    end
    q = fshr(z + 8, 4);
    if (q > 12868) q = 12868;
    if (q < -12868) q = -12868;
    return q;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, bitv;
    r = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic steer_t predict_steer(logic signed [15:0] hx, hy, lx, ly, tx, ty);
    steer_t s;
    longint change, turn, mag, distance, ddx, ddy, trans, deg;
    s.turn_deg = '0;
    s.translate = '0;
    if (sh_mode) return s;
    turn = 0;
    trans = 0;
    ddx = longint'(tx) - longint'(ly - ly + lx);
    ddy = longint'(ty) - longint'(ly);
    change = bearing_q12(longint'(hx) - longint'(lx), longint'(hy) - longint'(ly))
             - bearing_q12(ddx, ddy);
    while (change > 6434) change -= 12868;
    mag = change < 0 ? -change : change;
    if (mag > longint'(sh_deadband)) turn = change;
    distance = int_sqrt(ddx * ddx + ddy * ddy);
    mag = turn < 0 ? -turn : turn;
    if (distance > longint'(sh_arrive) && mag < longint'(sh_tlimit))
      trans = distance < longint'(sh_maxspd) ? distance : longint'(sh_maxspd);
    mag = (mag * 11520 + 6434) / 12868;
    deg = turn < 0 ? -mag : mag;
    if (deg < -23040) deg = -23040;
    if (deg > 5760) deg = 5760;
    s.turn_deg = deg[15:0];
    s.translate = trans[15:0];
    return s;
  endfunction

  // Append one expected result to the scoreboard
  task automatic queue_expect(steer_t s);
    steer_q.insert(steer_q.size(), s);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_MODE:     sh_mode = val[0];
      REG_DEADBAND: sh_deadband = val[11:0];
      REG_ARRIVE:   sh_arrive = val;
      REG_TLIMIT:   sh_tlimit = val[13:0];
      REG_MAXSPD:   sh_maxspd = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Send one beat after a random gap (none when no_gap is set); prediction is queued on acceptance
  task automatic send_beat(logic signed [15:0] hx, hy, lx, ly, tx, ty, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    repeat (gap) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.heading_x = hx;
    in_ch.heading_y = hy;
    in_ch.location_x = lx;
    in_ch.location_y = ly;
    in_ch.dest_x = tx;
    in_ch.dest_y = ty;
    do @(posedge clk); while (!in_ch.ready);
    queue_expect(predict_steer(hx, hy, lx, ly, tx, ty));
    n_beats++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Wait until the scoreboard is empty, then allow the pipeline latency to pass
  task automatic drain;
    while (steer_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // Result checker and receiver stall
  initial begin
    int stall;
    steer_t exp_s;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      repeat (stall) @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!(out_ch.valid && !rst));
      if (steer_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result beat turn=%0d trans=%0d",
                                  out_ch.turn_deg, out_ch.translate);
      end else begin
        exp_s = steer_q.pop_front();
        n_results++;
        if (exp_s.turn_deg != 0) n_turns++;
        if (exp_s.translate != 0) n_moves++;
        if (out_ch.turn_deg !== exp_s.turn_deg || out_ch.translate !== exp_s.translate) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: turn exp %0d got %0d, translate exp %0d got %0d",
                     exp_s.turn_deg, out_ch.turn_deg, exp_s.translate, out_ch.translate);
        end
      end
      @(negedge clk);
      out_ch.ready = 1'b0;
    end
  end

  function automatic logic signed [15:0] rnd_coord();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
    endcase
  endfunction

  task automatic test_extremes;
    logic signed [15:0] mx, mn;
    mx = 16'sh7fff;
    mn = 16'sh8000;
    // zero vectors and coincident points
    send_beat(0, 0, 0, 0, 0, 0);
    send_beat(100, 200, 100, 200, 100, 200);
    // full-scale corners
    send_beat(mx, mx, mn, mn, mx, mx);
    send_beat(mn, mn, mx, mx, mn, mn);
    send_beat(mx, mn, mn, mx, mn, mx);
    send_beat(mn, mx, mx, mn, mx, mn);
    send_beat(mn, 0, 0, 0, 0, mx);
    send_beat(0, mn, 0, 0, mn, 0);
    // straight ahead, behind, left, right, negative-x quadrant both signs
    send_beat(0, 256, 0, 0, 0, 2560);
    send_beat(0, 256, 0, 0, 0, -2560);
    send_beat(0, 256, 0, 0, -2560, 0);
    send_beat(0, 256, 0, 0, 2560, 0);
    send_beat(-256, 1, 0, 0, -256, -1);
    send_beat(-256, -1, 0, 0, -256, 1);
    // near-deadband and short distances
    send_beat(0, 4096, 0, 0, 3, 4096);
    send_beat(0, 256, 0, 0, 0, 26);
    send_beat(0, 256, 0, 0, 0, 27);
    drain();
  endtask

  task automatic test_registers;
    write_reg(REG_MODE, 16'd1);
    send_beat(0, 256, 0, 0, 2560, 0);
    send_beat(16'sh7fff, 0, 16'sh8000, 0, 0, 16'sh7fff);
    drain();
    write_reg(REG_MODE, 16'd0);
    write_reg(REG_DEADBAND, 16'hffff);
    write_reg(REG_ARRIVE, 16'd0);
    write_reg(REG_TLIMIT, 16'd12868);
    write_reg(REG_MAXSPD, 16'hffff);
    repeat (8) send_beat(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                         rnd_coord(), rnd_coord());
    drain();
    write_reg(REG_DEADBAND, 16'd0);
    write_reg(REG_ARRIVE, 16'hffff);
    write_reg(REG_TLIMIT, 16'd0);
    write_reg(REG_MAXSPD, 16'd0);
    repeat (8) send_beat(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                         rnd_coord(), rnd_coord());
    drain();
  endtask

  task automatic test_random;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MODE, (ph == 3) ? 16'd1 : 16'd0);
      write_reg(REG_DEADBAND, 16'($urandom_range(0, 4095)));
      write_reg(REG_ARRIVE, 16'($urandom_range(0, 2048)));
      write_reg(REG_TLIMIT, 16'($urandom_range(0, 12868)));
      write_reg(REG_MAXSPD, 16'($urandom));
      for (int k = 0; k < 200; k++) begin
        send_beat(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                  rnd_coord(), rnd_coord(), (ph == 2) || (k % 50 < 10));
      end
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.heading_x = '0;
    in_ch.heading_y = '0;
    in_ch.location_x = '0;
    in_ch.location_y = '0;
    in_ch.dest_x = '0;
    in_ch.dest_y = '0;
    sh_mode = 1'b0;
    sh_deadband = 12'd4;
    sh_arrive = 16'd26;
    sh_tlimit = 14'd1229;
    sh_maxspd = 16'd384;
    n_err = 0;
    n_beats = 0;
    n_results = 0;
    n_turns = 0;
    n_moves = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extremes();
    test_registers();
    test_random();

    $display("Sent %0d beats, checked %0d results (%0d turning, %0d translating),",
             n_beats, n_results, n_turns, n_moves);
    $display("over reset defaults, test mode and extreme register settings.");
    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", n_err);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/pts_pkg.sv
src/pts_if.sv
src/pts_cordic.sv
src/pts_isqrt.sv
src/point_to_point_steering_top.sv
test/testbench.sv
